// ----- design/hffs_pkg.sv -----
package hffs_pkg;

   localparam int HALF_MAX     = 128;
   localparam int MAX_ELEMENTS = 4096;
   localparam int FRAC_BITS    = 24;

   localparam int HALF_BITS = $clog2(HALF_MAX);
   localparam int TBL_AW    = 2 * HALF_BITS;
   localparam int TBL_DEPTH = HALF_MAX * HALF_MAX;
   localparam int ACC_AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int FACTOR_W  = FRAC_BITS;
   localparam int ACC_W     = FRAC_BITS + 1;

   localparam int COORD_W = 8;
   localparam int ID_W    = 24;
   localparam int FV_W    = 24;
   localparam int HRES_W  = 8;
   localparam int BGID_W  = 24;
   localparam int READ_W  = 25;

   localparam logic [HRES_W-1:0] HALF_RES_RESET = 8'd100;
   localparam logic [BGID_W-1:0] BG_ID_RESET    = 24'hFF_FFFF;

   // register indexes on the csr port
   localparam logic REG_HALF_RES = 1'b0;
   localparam logic REG_BG_ID    = 1'b1;

   typedef enum logic [2:0] {
      OP_LOAD_TOP  = 3'd0,
      OP_LOAD_SIDE = 3'd1,
      OP_TOP_PIXEL = 3'd2,
      OP_SIDE_PIXEL= 3'd3,
      OP_READ      = 3'd4,
      OP_CLEAR     = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SKIP  = 3'd1,
      ST_ID    = 3'd2,
      ST_COORD = 3'd3,
      ST_SAT   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [ID_W-1:0]    element_id;
      logic [FV_W-1:0]    factor_value;
   } item_type;

   typedef struct packed {
      status_type status;
      logic       load_top;
      logic       load_side;
      logic       add;
      logic       side;
      logic       clear;
      logic       read;
   } plan_type;

   // quarter-face fold: c below h stays, else mirrored to 2h-1-c
   function automatic logic [COORD_W:0] fold(input logic [COORD_W-1:0] c,
                                             input logic [HRES_W-1:0] h);
      logic [COORD_W:0] two_h;
      two_h = {1'b0, h, 1'b0} > 0 ? {h, 1'b0} : '0;
      if ({1'b0, c} < {1'b0, h})
         return {1'b0, c};
      else
         return two_h - {{COORD_W{1'b0}}, 1'b1} - {1'b0, c};
   endfunction

endpackage

// ----- design/hemicube_form_factor_sum_core.sv -----
// channel | dir | tdata (low bit up)                         | tuser
// req_    | in  | row 8, col 8, element_id 24, factor_value 24 | opcode 3
// rsp_    | out | read_value 25, zero pad 7                   | status 3
// csr_    | in  | index 0 half_resolution, 1 background_id    | -
// Each beat goes through accept, table and accumulator read (registered
// memory read), then read-modify-write of the accumulator.
// The next beat is accepted while the previous result waits in the output
// register; the update stage holds until that register is free.
// Reset sets the control state and the two registers; memories keep content.
module hemicube_form_factor_sum_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // row, col, element_id, factor_value
   input  logic [2:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value, zero pad
   output logic [2:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [hffs_pkg::BGID_W-1:0] csr_wdata
);
   import hffs_pkg::*;

   localparam logic [COORD_W:0] HALF_MAX_W = (COORD_W+1)'(HALF_MAX);
   localparam logic [ID_W-1:0]  ID_LIMIT   = ID_W'(MAX_ELEMENTS);

   state_type state_ff, state_in;
   item_type  item_ff;
   plan_type  plan_ff, plan_in;

   logic [HRES_W-1:0] half_res_ff;
   logic [BGID_W-1:0] bg_id_ff;

   logic [FACTOR_W-1:0] top_mem  [TBL_DEPTH];
   logic [FACTOR_W-1:0] side_mem [TBL_DEPTH];
   logic [ACC_W-1:0]    acc_mem  [MAX_ELEMENTS];
   logic [FACTOR_W-1:0] top_rd_ff, side_rd_ff;
   logic [ACC_W-1:0]    acc_rd_ff;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [READ_W-1:0] rsp_value_ff;

   logic accept, lookup, commit;

   // decode
   logic [COORD_W:0]    two_h, frow, fcol;
   logic                bad_h, off_face, id_out, load_off;
   logic [TBL_AW-1:0]   pix_addr, load_addr;
   logic [ACC_AW-1:0]   acc_addr;
   logic [ACC_W:0]      sum;
   logic [FACTOR_W-1:0] factor;
   logic                sat;
   status_type          status_out;
   logic [ACC_W-1:0]    acc_wdata;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_UPDATE;
         S_UPDATE: if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      lookup     = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         S_IDLE:   req_tready = 1'b1;
         S_LOOKUP: lookup = 1'b1;
         S_UPDATE: commit = !rsp_valid_ff || rsp_tready;
         default:  req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      two_h    = {half_res_ff, 1'b0};
      bad_h    = (half_res_ff == '0) || ({1'b0, half_res_ff} > HALF_MAX_W);
      off_face = ({1'b0, item_ff.row} >= two_h) || ({1'b0, item_ff.col} >= two_h);
      frow     = fold(item_ff.row, half_res_ff);
      fcol     = fold(item_ff.col, half_res_ff);
      pix_addr = {frow[HALF_BITS-1:0], fcol[HALF_BITS-1:0]};
      load_off = ({1'b0, item_ff.row} >= HALF_MAX_W) ||
                 ({1'b0, item_ff.col} >= HALF_MAX_W);
      load_addr = {item_ff.row[HALF_BITS-1:0], item_ff.col[HALF_BITS-1:0]};
      id_out   = item_ff.element_id >= ID_LIMIT;
      acc_addr = item_ff.element_id[ACC_AW-1:0];

      plan_in = '{status: ST_OK, load_top: 1'b0, load_side: 1'b0, add: 1'b0,
                  side: 1'b0, clear: 1'b0, read: 1'b0};
      case (opcode_type'(item_ff.opcode))
         OP_LOAD_TOP, OP_LOAD_SIDE: begin
            if (load_off)
               plan_in.status = ST_COORD;
            else if (opcode_type'(item_ff.opcode) == OP_LOAD_TOP)
               plan_in.load_top = 1'b1;
            else
               plan_in.load_side = 1'b1;
         end
         OP_TOP_PIXEL, OP_SIDE_PIXEL: begin
            plan_in.side = opcode_type'(item_ff.opcode) == OP_SIDE_PIXEL;
            if (bad_h || off_face)
               plan_in.status = ST_COORD;
            else if (plan_in.side && ({1'b0, item_ff.row} < {1'b0, half_res_ff}))
               plan_in.status = ST_SKIP;
            else if (item_ff.element_id == bg_id_ff)
               plan_in.status = ST_SKIP;
            else if (id_out)
               plan_in.status = ST_ID;
            else
               plan_in.add = 1'b1;
         end
         OP_READ: begin
            if (id_out) plan_in.status = ST_ID;
            else        plan_in.read = 1'b1;
         end
         OP_CLEAR: begin
            if (id_out) plan_in.status = ST_ID;
            else        plan_in.clear = 1'b1;
         end
         default: plan_in.status = ST_SKIP;
      endcase
   end

   // accumulator update
   always_comb begin
      factor     = plan_ff.side ? side_rd_ff : top_rd_ff;
      sum        = {1'b0, acc_rd_ff} + {{(ACC_W+1-FACTOR_W){1'b0}}, factor};
      sat        = sum[ACC_W];
      status_out = plan_ff.status;
      if (plan_ff.add && sat) status_out = ST_SAT;
      if (plan_ff.clear)
         acc_wdata = '0;
      else if (sat)
         acc_wdata = '1;
      else
         acc_wdata = sum[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         half_res_ff  <= HALF_RES_RESET;
         bg_id_ff     <= BG_ID_RESET;
      end else begin
         state_ff <= state_in;
         if (commit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            if (csr_index == REG_HALF_RES)
               half_res_ff <= csr_wdata[HRES_W-1:0];
            else
               bg_id_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode       <= req_tuser;
         item_ff.row          <= req_tdata[7:0];
         item_ff.col          <= req_tdata[15:8];
         item_ff.element_id   <= req_tdata[39:16];
         item_ff.factor_value <= req_tdata[63:40];
      end
      if (lookup)
         plan_ff <= plan_in;
      if (commit) begin
         rsp_status_ff <= status_out;
         rsp_value_ff  <= plan_ff.read ? READ_W'(acc_rd_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && plan_ff.load_top)
         top_mem[load_addr] <= item_ff.factor_value[FACTOR_W-1:0];
      if (lookup)
         top_rd_ff <= top_mem[pix_addr];
   end

   always_ff @(posedge clock) begin
      if (commit && plan_ff.load_side)
         side_mem[load_addr] <= item_ff.factor_value[FACTOR_W-1:0];
      if (lookup)
         side_rd_ff <= side_mem[pix_addr];
   end

   always_ff @(posedge clock) begin
      if (commit && (plan_ff.add || plan_ff.clear))
         acc_mem[acc_addr] <= acc_wdata;
      if (lookup)
         acc_rd_ff <= acc_mem[acc_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(32-READ_W){1'b0}}, rsp_value_ff};

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_LOOKUP)
      else $error("accepted beat not looked up");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("result raised outside update");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_value_ff == '0)
      else $error("read value on failed result");

   a_single_action: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> $onehot0({plan_ff.load_top, plan_ff.load_side,
                                          plan_ff.add, plan_ff.clear, plan_ff.read}))
      else $error("more than one memory action planned");

endmodule
